[rtl/core/border_connected_region_fill_core_macros.svh]
// Assertion macros for the border region fill core.
// Depends on nothing; included by the core top level.
`ifndef BORDER_CONNECTED_REGION_FILL_CORE_MACROS_SVH
`define BORDER_CONNECTED_REGION_FILL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BCRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcrf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BCRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcrf assertion failed");

`endif

[rtl/core/bcrf_pkg.sv]
// Shared types and constants for the border region fill core.
// No dependencies.
package bcrf_pkg;

    // fixed field widths
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // parameter defaults
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    typedef logic [CNT_W-1:0] t_cnt;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    // reset values of the registers
    localparam t_cnt RST_ROW_COUNT = 7'd64;
    localparam t_cnt RST_COL_COUNT = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_OPRIME,
        S_SEND
    } t_state;

endpackage

[rtl/core/border_connected_region_fill_core.sv]
// Border region fill core: loads a grid one row per beat, then sweeps the stored rows
// down and up, pass after pass, until a pass adds no cell. The number of passes (at
// least one) depends on how often a region path turns back against the sweep direction.
// Output: a priming state (S_OPRIME), then one row per cycle while the sink does not stall.
// Reset (sync, active low) clears control state; row and column counts go to 64.
// Grid and reach memories are not cleared; each grid rewrites every row it reads.
module border_connected_region_fill_core #(
    parameter int MAX_ROWS = bcrf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = bcrf_pkg::DEF_MAX_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bcrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcrf_pkg::CFG_W-1:0]      i_cfg_data,
    // input rows
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bcrf_pkg::DATA_W-1:0]     i_open_row,
    // result rows
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bcrf_pkg::DATA_W-1:0]     o_result_row,
    output logic                            o_last_row
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam bcrf_pkg::t_cnt MAX_ROWS_C = bcrf_pkg::CNT_W'(MAX_ROWS);
    localparam bcrf_pkg::t_cnt MAX_COLS_C = bcrf_pkg::CNT_W'(MAX_COLS);
    localparam logic [MAX_COLS-1:0] ONES  = '1;
    localparam logic [MAX_COLS-1:0] ONE   = MAX_COLS'(1);

    typedef logic [MAX_COLS-1:0] t_row;

    // upward fill of seeds x through runs of open cells g (x inside g)
    function automatic t_row fill_up(input t_row g, input t_row x);
        t_row s;
        s = g + x;
        return ((s ^ g) | x) & g;
    endfunction

    function automatic t_row rev(input t_row v);
        t_row r;
        for (int j = 0; j < MAX_COLS; j++) begin
            r[j] = v[MAX_COLS-1-j];
        end
        return r;
    endfunction

    // full horizontal fill inside the row: both directions
    function automatic t_row row_fill(input t_row g, input t_row x);
        return fill_up(g, x) | rev(fill_up(rev(g), rev(x)));
    endfunction

    // ---------------------------------------------------------------
    // registers
    bcrf_pkg::t_state r_state, n_state;
    bcrf_pkg::t_cnt   r_row_count, r_col_count;
    bcrf_pkg::t_cnt   r_load, n_load;
    bcrf_pkg::t_cnt   r_step, n_step;
    bcrf_pkg::t_cnt   r_idx, n_idx;
    logic             r_dir, n_dir;
    logic             r_first, n_first;
    logic             r_chg, n_chg;
    t_row             r_cur_r, n_cur_r;
    t_row             r_cur_g, n_cur_g;
    t_row             r_prev_r, n_prev_r;
    t_row             r_reach_rd, r_grid_rd;

    t_row r_grid_mem  [MAX_ROWS];
    t_row r_reach_mem [MAX_ROWS];

    // ---------------------------------------------------------------
    // effective counts and masks
    bcrf_pkg::t_cnt rows, cols, rows_p1, load_p1;
    t_row           col_mask, edge_mask;

    always_comb begin
        if (r_row_count == '0) begin
            rows = bcrf_pkg::CNT_W'(1);
        end else if (r_row_count > MAX_ROWS_C) begin
            rows = MAX_ROWS_C;
        end else begin
            rows = r_row_count;
        end
        if (r_col_count == '0) begin
            cols = bcrf_pkg::CNT_W'(1);
        end else if (r_col_count > MAX_COLS_C) begin
            cols = MAX_COLS_C;
        end else begin
            cols = r_col_count;
        end
    end

    assign rows_p1   = rows + bcrf_pkg::CNT_W'(1);
    assign load_p1   = r_load + bcrf_pkg::CNT_W'(1);
    assign col_mask  = ONES >> (MAX_COLS_C - cols);
    assign edge_mask = ONE | (ONE << (cols - bcrf_pkg::CNT_W'(1)));

    // handshakes
    logic in_acc, out_acc;
    assign o_stall = (r_state != bcrf_pkg::S_IDLE);
    assign o_valid = (r_state == bcrf_pkg::S_SEND);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // ---------------------------------------------------------------
    // sweep datapath
    bcrf_pkg::t_cnt rd_pos_row, wr_pos_row, in_pos_row, rd_sel;
    t_row           in_r, nxt_r, new_row;
    logic           chg_now;

    // row number of a position in the current sweep direction
    always_comb begin
        rd_pos_row = r_dir ? (rows - bcrf_pkg::CNT_W'(1) - r_step) : r_step;
        in_pos_row = r_dir ? (rows - r_step) : (r_step - bcrf_pkg::CNT_W'(1));
        wr_pos_row = r_dir ? (rows + bcrf_pkg::CNT_W'(1) - r_step)
                           : (r_step - bcrf_pkg::CNT_W'(2));
    end

    // row arriving from memory; first pass uses border seeds instead
    always_comb begin
        if (!r_first) begin
            in_r = r_reach_rd;
        end else if (in_pos_row == '0 || in_pos_row == rows - bcrf_pkg::CNT_W'(1)) begin
            in_r = r_grid_rd;
        end else begin
            in_r = r_grid_rd & edge_mask;
        end
    end

    // neighbors above and below seed the row, then spread along it
    assign nxt_r   = (r_step <= rows) ? in_r : '0;
    assign new_row = row_fill(r_cur_g, r_cur_r | ((r_prev_r | nxt_r) & r_cur_g));
    assign chg_now = (new_row != r_cur_r);

    // ---------------------------------------------------------------
    // next state and memory controls
    logic grid_we, reach_we;

    always_comb begin
        n_state  = r_state;
        n_load   = r_load;
        n_step   = r_step;
        n_idx    = r_idx;
        n_dir    = r_dir;
        n_first  = r_first;
        n_chg    = r_chg;
        n_cur_r  = r_cur_r;
        n_cur_g  = r_cur_g;
        n_prev_r = r_prev_r;
        grid_we  = 1'b0;
        reach_we = 1'b0;
        rd_sel   = r_idx;

        unique case (r_state)
            bcrf_pkg::S_IDLE: begin
                if (in_acc) begin
                    grid_we = 1'b1;
                    n_load  = load_p1;
                    if (load_p1 >= rows) begin
                        n_load   = '0;
                        n_state  = bcrf_pkg::S_FILL;
                        n_step   = '0;
                        n_dir    = 1'b0;
                        n_first  = 1'b1;
                        n_chg    = 1'b0;
                        n_prev_r = '0;
                    end
                end
            end
            bcrf_pkg::S_FILL: begin
                rd_sel = rd_pos_row;
                n_step = r_step + bcrf_pkg::CNT_W'(1);
                // slide the window by one row in the sweep direction
                if (r_step != '0) begin
                    n_cur_r = in_r;
                    n_cur_g = r_grid_rd;
                end
                if (r_step >= bcrf_pkg::CNT_W'(2)) begin
                    reach_we = 1'b1;
                    n_prev_r = new_row;
                    if (chg_now) begin
                        n_chg = 1'b1;
                    end
                end
                // end of a sweep: turn around or finish
                if (r_step == rows_p1) begin
                    if (r_chg || chg_now) begin
                        n_step   = '0;
                        n_dir    = !r_dir;
                        n_first  = 1'b0;
                        n_chg    = 1'b0;
                        n_prev_r = '0;
                    end else begin
                        n_state = bcrf_pkg::S_OPRIME;
                    end
                end
            end
            bcrf_pkg::S_OPRIME: begin
                rd_sel  = '0;
                n_idx   = '0;
                n_state = bcrf_pkg::S_SEND;
            end
            bcrf_pkg::S_SEND: begin
                // read ahead on a taken beat so rows stream back to back
                if (out_acc) begin
                    rd_sel = r_idx + bcrf_pkg::CNT_W'(1);
                    n_idx  = r_idx + bcrf_pkg::CNT_W'(1);
                    if (o_last_row) begin
                        n_state = bcrf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bcrf_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bcrf_pkg::S_IDLE;
            r_row_count <= bcrf_pkg::RST_ROW_COUNT;
            r_col_count <= bcrf_pkg::RST_COL_COUNT;
            r_load      <= '0;
            r_step      <= '0;
            r_idx       <= '0;
            r_dir       <= 1'b0;
            r_first     <= 1'b0;
            r_chg       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_load  <= n_load;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_dir   <= n_dir;
            r_first <= n_first;
            r_chg   <= n_chg;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bcrf_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data;
                    bcrf_pkg::REG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // sweep window
    always_ff @(posedge i_clk) begin
        r_cur_r  <= n_cur_r;
        r_cur_g  <= n_cur_g;
        r_prev_r <= n_prev_r;
    end

    // grid memory: written on load beats, read every cycle
    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid_mem[r_load[AW-1:0]] <= i_open_row[MAX_COLS-1:0] & col_mask;
        end
        r_grid_rd <= r_grid_mem[rd_sel[AW-1:0]];
    end

    // reach memory: written by the sweep, read every cycle
    always_ff @(posedge i_clk) begin
        if (reach_we) begin
            r_reach_mem[wr_pos_row[AW-1:0]] <= new_row;
        end
        r_reach_rd <= r_reach_mem[rd_sel[AW-1:0]];
    end

    // result beat straight from the reach read register
    assign o_result_row = bcrf_pkg::DATA_W'(r_reach_rd);
    assign o_last_row   = (r_idx == rows - bcrf_pkg::CNT_W'(1));

    // ---------------------------------------------------------------
    // assertions
`include "border_connected_region_fill_core_macros.svh"

    `BCRF_ASSERT_SAME(a_no_load_while_sending, i_clk, i_rst_n, o_valid, o_stall)
    `BCRF_ASSERT_NEXT(a_full_grid_starts_fill, i_clk, i_rst_n, in_acc && (load_p1 >= rows), r_state == bcrf_pkg::S_FILL && r_step == '0 && r_first)
    `BCRF_ASSERT_SAME(a_step_in_range, i_clk, i_rst_n, r_state == bcrf_pkg::S_FILL, r_step <= rows_p1)
    `BCRF_ASSERT_NEXT(a_last_beat_ends_grid, i_clk, i_rst_n, out_acc && o_last_row, !o_valid && !o_stall)

endmodule

[tb/border_connected_region_fill_core_test.sv]
// Self-checking testbench for border_connected_region_fill_core.
// Needs bcrf_pkg and the core; directed grids first, then random grids checked
// against an in-bench flood fill predictor.
`timescale 1ns / 100ps

module border_connected_region_fill_core_test;

    typedef struct {
        logic [bcrf_pkg::DATA_W-1:0] row;
        logic                        last;
    } t_fill_row;

    typedef enum {
        STEP_SET_ROWS,
        STEP_SET_COLS,
        STEP_ROW
    } t_step_kind;

    typedef struct {
        t_step_kind                  kind;
        logic [bcrf_pkg::DATA_W-1:0] val;
        bit                          typed;
        logic [bcrf_pkg::DATA_W-1:0] want;
    } t_step;

    localparam int DIR_N      = 34;
    localparam int RAND_ITEMS = 250;

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [bcrf_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [bcrf_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_valid    = 1'b0;
    logic                           o_stall;
    logic [bcrf_pkg::DATA_W-1:0]    i_open_row = '0;
    logic                           o_valid;
    logic                           i_stall    = 1'b0;
    logic [bcrf_pkg::DATA_W-1:0]    o_result_row;
    logic                           o_last_row;

    border_connected_region_fill_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_open_row   (i_open_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result_row (o_result_row),
        .o_last_row   (o_last_row)
    );

    // predictor state
    logic [bcrf_pkg::DATA_W-1:0] grid_mem [64];
    bcrf_pkg::t_cnt              load_cnt;
    bcrf_pkg::t_cnt              cfg_rows;
    bcrf_pkg::t_cnt              cfg_cols;
    t_fill_row                   fill_q [$];

    // checker and idling state
    int        err_cnt   = 0;
    bit        src_busy  = 1'b1;
    bit        snk_busy  = 1'b1;
    int        hold_left = 0;
    t_fill_row head;
    bit        got_bad;
    t_step     dir_plan [DIR_N];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #40_000_000;
        $display("border_connected_region_fill_core_test: FAIL");
        $finish;
    end

    function automatic int rows_in_use();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > bcrf_pkg::DEF_MAX_ROWS) return bcrf_pkg::DEF_MAX_ROWS;
        return int'(cfg_rows);
    endfunction

    function automatic int cols_in_use();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > bcrf_pkg::DEF_MAX_COLS) return bcrf_pkg::DEF_MAX_COLS;
        return int'(cfg_cols);
    endfunction

    function automatic logic [bcrf_pkg::DATA_W-1:0] col_bits(input int nc);
        if (nc >= bcrf_pkg::DATA_W) return '1;
        return (64'd1 << nc) - 64'd1;
    endfunction

    // mostly short gaps, a few long ones; none while the side runs flat out
    function automatic int pick_gap(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Flood from the border until a sweep adds nothing, then queue the rows.
    function automatic void flood_grid(input int nr, input int nc);
        logic [bcrf_pkg::DATA_W-1:0] reach [64];
        logic [bcrf_pkg::DATA_W-1:0] side;
        logic [bcrf_pkg::DATA_W-1:0] grow;
        logic [bcrf_pkg::DATA_W-1:0] nxt;
        bit                          changed;
        side = 64'd1 | (64'd1 << (nc - 1));
        for (int i = 0; i < nr; i++)
            reach[i] = (i == 0 || i == nr - 1) ? grid_mem[i] : (grid_mem[i] & side);
        do begin
            changed = 1'b0;
            for (int i = 0; i < nr; i++) begin
                grow = (reach[i] << 1) | (reach[i] >> 1);
                if (i > 0) grow |= reach[i-1];
                if (i + 1 < nr) grow |= reach[i+1];
                nxt = reach[i] | (grow & grid_mem[i]);
                if (nxt != reach[i]) begin
                    reach[i] = nxt;
                    changed  = 1'b1;
                end
            end
        end while (changed);
        for (int i = 0; i < nr; i++)
            fill_q.push_back('{reach[i], (i == nr - 1)});
    endfunction

    // Predictor step for one accepted input beat.
    function automatic void take_row(input logic [bcrf_pkg::DATA_W-1:0] v);
        int nr;
        int nc;
        nr = rows_in_use();
        nc = cols_in_use();
        grid_mem[load_cnt[5:0]] = v & col_bits(nc);
        load_cnt = load_cnt + 1'b1;
        if (int'(load_cnt) < nr) return;
        flood_grid(nr, nc);
        load_cnt = '0;
    endfunction

    // Drop valid, let every queued row drain, then give the core time to settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (fill_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bcrf_pkg::CFG_IDX_W-1:0] idx,
                             input bcrf_pkg::t_cnt v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bcrf_pkg::REG_ROW_COUNT) cfg_rows = v;
        else cfg_cols = v;
    endtask

    // One input beat; valid stays high when the next beat follows at once.
    task automatic send_row(input logic [bcrf_pkg::DATA_W-1:0] v);
        int gap;
        gap = pick_gap(src_busy);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_open_row <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        take_row(v);
    endtask

    function automatic logic [bcrf_pkg::DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Row content by density class: plain, sparse, dense, very dense, solid.
    function automatic logic [bcrf_pkg::DATA_W-1:0] make_row(input int density);
        case (density)
            0: return rand_word();
            1: return rand_word() & rand_word();
            2: return rand_word() | rand_word();
            3: return rand_word() | rand_word() | rand_word();
            default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    function automatic bcrf_pkg::t_cnt pick_rows(inout int big_left);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 9 && big_left > 0) begin
            big_left--;
            return ($urandom_range(0, 1) != 0) ? bcrf_pkg::t_cnt'(64)
                                               : bcrf_pkg::t_cnt'($urandom_range(65, 127));
        end
        if (r < 75) return bcrf_pkg::t_cnt'($urandom_range(1, 6));
        return bcrf_pkg::t_cnt'($urandom_range(7, 16));
    endfunction

    function automatic bcrf_pkg::t_cnt pick_cols();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 12) return bcrf_pkg::t_cnt'(64);
        if (r < 17) return bcrf_pkg::t_cnt'($urandom_range(65, 127));
        if (r < 40) return bcrf_pkg::t_cnt'($urandom_range(1, 6));
        return bcrf_pkg::t_cnt'($urandom_range(7, 63));
    endfunction

    // Sink side: random stall runs, most short, a few long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!snk_busy) begin
            i_stall <= 1'b0;
        end else begin
            i_stall   <= ($urandom_range(0, 2) == 0);
            hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 3);
        end
    end

    // Result checker: each accepted beat against the oldest queued row.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (fill_q.size() == 0) begin
                head    = '{'0, 1'b0};
                got_bad = 1'b1;
            end else begin
                head    = fill_q.pop_front();
                got_bad = (o_result_row !== head.row) || (o_last_row !== head.last);
            end
            if (got_bad) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display({"mismatch at %0t: expected row %h last %b (%0d left),",
                              " got row %h last %b"},
                             $time, head.row, head.last, fill_q.size(),
                             o_result_row, o_last_row);
            end
        end
    end

    initial begin
        int items;
        int big_left;
        int density;

        // directed grids; typed rows are single-row grids, so all cells are border
        dir_plan = '{
            '{STEP_SET_ROWS, 64'd1, 1'b0, '0},
            '{STEP_ROW, '1, 1'b1, '1},
            '{STEP_ROW, '0, 1'b1, '0},
            '{STEP_ROW, 64'h8000_0000_0000_0001, 1'b1, 64'h8000_0000_0000_0001},
            '{STEP_SET_COLS, 64'd1, 1'b0, '0},
            '{STEP_ROW, '1, 1'b1, 64'h1},
            '{STEP_SET_COLS, 64'd0, 1'b0, '0},
            '{STEP_ROW, '1, 1'b1, 64'h1},
            '{STEP_SET_COLS, 64'd127, 1'b0, '0},
            '{STEP_ROW, 64'h5555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555},
            '{STEP_SET_COLS, 64'd5, 1'b0, '0},
            '{STEP_ROW, '1, 1'b1, 64'h1f},
            '{STEP_SET_ROWS, 64'd0, 1'b0, '0},
            '{STEP_ROW, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 64'h0a},
            // enclosed center cell
            '{STEP_SET_ROWS, 64'd3, 1'b0, '0},
            '{STEP_SET_COLS, 64'd3, 1'b0, '0},
            '{STEP_ROW, 64'h0, 1'b0, '0},
            '{STEP_ROW, 64'h2, 1'b0, '0},
            '{STEP_ROW, 64'h0, 1'b0, '0},
            // row count lowered below the rows already loaded
            '{STEP_SET_ROWS, 64'd4, 1'b0, '0},
            '{STEP_SET_COLS, 64'd4, 1'b0, '0},
            '{STEP_ROW, 64'h6, 1'b0, '0},
            '{STEP_ROW, 64'h9, 1'b0, '0},
            '{STEP_ROW, 64'hf, 1'b0, '0},
            '{STEP_SET_ROWS, 64'd2, 1'b0, '0},
            '{STEP_ROW, 64'h3, 1'b0, '0},
            // winding path that has to climb back up
            '{STEP_SET_ROWS, 64'd6, 1'b0, '0},
            '{STEP_SET_COLS, 64'd6, 1'b0, '0},
            '{STEP_ROW, 64'h00, 1'b0, '0},
            '{STEP_ROW, 64'h0e, 1'b0, '0},
            '{STEP_ROW, 64'h0a, 1'b0, '0},
            '{STEP_ROW, 64'h1a, 1'b0, '0},
            '{STEP_ROW, 64'h13, 1'b0, '0},
            '{STEP_ROW, 64'h00, 1'b0, '0}
        };

        load_cnt = '0;
        cfg_rows = bcrf_pkg::RST_ROW_COUNT;
        cfg_cols = bcrf_pkg::RST_COL_COUNT;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            case (dir_plan[k].kind)
                STEP_SET_ROWS: write_reg(bcrf_pkg::REG_ROW_COUNT,
                                         dir_plan[k].val[bcrf_pkg::CFG_W-1:0]);
                STEP_SET_COLS: write_reg(bcrf_pkg::REG_COL_COUNT,
                                         dir_plan[k].val[bcrf_pkg::CFG_W-1:0]);
                default: begin
                    send_row(dir_plan[k].val);
                    if (dir_plan[k].typed) begin
                        void'(fill_q.pop_back());
                        fill_q.push_back('{dir_plan[k].want, 1'b1});
                    end
                end
            endcase
        end

        // random grids, with the odd row count change part way through a grid
        items    = 0;
        big_left = 2;
        while (items < RAND_ITEMS) begin
            if (items == 0 || $urandom_range(0, 2) == 0) begin
                write_reg(bcrf_pkg::REG_ROW_COUNT, pick_rows(big_left));
                if ($urandom_range(0, 1) != 0)
                    write_reg(bcrf_pkg::REG_COL_COUNT, pick_cols());
            end
            src_busy = ($urandom_range(0, 4) != 0);
            snk_busy = ($urandom_range(0, 4) != 0);
            density  = $urandom_range(0, 4);
            do begin
                if (load_cnt != 0 && $urandom_range(0, 15) == 0)
                    write_reg(bcrf_pkg::REG_ROW_COUNT,
                              bcrf_pkg::t_cnt'($urandom_range(0, int'(load_cnt) + 2)));
                send_row(make_row(density));
                items++;
            end while (load_cnt != 0);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && fill_q.size() == 0) begin
            $display("border_connected_region_fill_core_test: PASS");
        end else begin
            $display("border_connected_region_fill_core_test: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bcrf_pkg.sv
rtl/core/border_connected_region_fill_core.sv
tb/border_connected_region_fill_core_test.sv
